FILE: rtl/core/vlns_pkg.sv
`timescale 1ns / 1ps

package vlns_pkg;

    localparam int WORD_W = 32;
    localparam int COMP_W = 16;
    localparam int ROOT_W = 16;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [COMP_W-1:0]        mag_t;
    typedef logic [ROOT_W-1:0]        root_t;

endpackage

FILE: rtl/core/vlns_divider.sv
`timescale 1ns / 1ps

module vlns_divider (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  vlns_pkg::word_t dividend,
    input  vlns_pkg::word_t divisor,
    output logic            done,
    output vlns_pkg::word_t quotient
);
    import vlns_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            div_reg, div_next;
    logic [WORD_W:0]  trial;
    logic [WORD_W+1:0] diff;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[WORD_W+1]) begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/vlns_sumsq.sv
`timescale 1ns / 1ps

module vlns_sumsq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  vlns_pkg::comp_t comp_x,
    input  vlns_pkg::comp_t comp_y,
    input  vlns_pkg::comp_t comp_z,
    output logic            done,
    output vlns_pkg::word_t sum
);
    import vlns_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [1:0] step_reg, step_next;
    mag_t       mag_x_reg, mag_y_reg, mag_z_reg;
    mag_t       mag_sel;
    word_t      prod_reg, prod_next;
    word_t      sum_reg, sum_next;

    function automatic mag_t magnitude(input comp_t v);
        magnitude = v[COMP_W-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
    endfunction

    always_comb begin
        unique case (step_reg)
            2'd0:    mag_sel = mag_x_reg;
            2'd1:    mag_sel = mag_y_reg;
            2'd2:    mag_sel = mag_z_reg;
            default: mag_sel = '0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        prod_next = prod_reg;
        sum_next  = sum_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            prod_next = '0;
            sum_next  = '0;
        end else if (busy_reg) begin
            prod_next = word_t'(mag_sel) * word_t'(mag_sel);
            sum_next  = sum_reg + prod_reg;
            step_next = step_reg + 1'b1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        if (start) begin
            mag_x_reg <= magnitude(comp_x);
            mag_y_reg <= magnitude(comp_y);
            mag_z_reg <= magnitude(comp_z);
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

FILE: rtl/core/vector_length_newton_sqrt.sv
`timescale 1ns / 1ps

// Floor square root of an unsigned Q16.16 radicand, or length of a 3-D vector
// with signed Q8.8 components, returned as unsigned Q8.8. One request is in
// work at a time; s_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next request is
// taken. A vector first sums its squares on one shared 16x16 multiplier.
// Each Newton step then runs one restoring division on the shared divider,
// and the steps repeat until the guess stops falling, at most MAX_ITERATIONS
// times. A zero radicand skips the divisions. Results beyond 16 bits
// saturate to 0xFFFF.
module vector_length_newton_sqrt #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_operation,
    input  vlns_pkg::word_t s_radicand,
    input  vlns_pkg::comp_t s_comp_x,
    input  vlns_pkg::comp_t s_comp_y,
    input  vlns_pkg::comp_t s_comp_z,
    output logic            m_valid,
    input  logic            m_ready,
    output vlns_pkg::root_t m_root
);
    import vlns_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_INIT = 3'd2;
    localparam logic [2:0] ST_GO   = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    word_t             n_reg, n_next;
    word_t             g_reg, g_next;
    logic              m_valid_reg, m_valid_next;
    root_t             m_root_reg, m_root_next;

    logic              accept;
    logic              sq_done;
    word_t             sq_sum;
    logic              div_start;
    logic              div_done;
    word_t             quotient;
    logic [WORD_W:0]   mean_sum;
    word_t             g_new;
    word_t             g_half;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign div_start = (state_reg == ST_GO);
    assign mean_sum  = {1'b0, g_reg} + {1'b0, quotient};
    assign g_new     = mean_sum[WORD_W:1];
    assign g_half    = n_reg >> 1;

    vlns_sumsq u_sumsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_operation),
        .comp_x  (s_comp_x),
        .comp_y  (s_comp_y),
        .comp_z  (s_comp_z),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    vlns_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        n_next       = n_reg;
        g_next       = g_reg;
        m_valid_next = m_valid_reg;
        m_root_next  = m_root_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_operation) begin
                        state_next = ST_SQ;
                    end else begin
                        n_next     = s_radicand;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_SQ: begin
                if (sq_done) begin
                    n_next     = sq_sum;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                iter_next = '0;
                if (n_reg == '0) begin
                    g_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    g_next     = (g_half == '0) ? word_t'(1) : g_half;
                    state_next = ST_GO;
                end
            end
            ST_GO: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (g_new >= g_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        g_next    = g_new;
                        iter_next = iter_reg + 1'b1;
                        if (iter_reg == ITER_W'(MAX_ITERATIONS - 1)) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_GO;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_root_next  = (g_reg[WORD_W-1:ROOT_W] != '0) ? '1 : g_reg[ROOT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        g_reg      <= g_next;
        m_root_reg <= m_root_next;
    end

    assign m_valid = m_valid_reg;
    assign m_root  = m_root_reg;

endmodule
